/* rtl/kdlp_pkg.sv */
// Shared types and constants for the four-key debounce and long-press block.
// No dependencies; used by kdlp_key and key_debounce_long_press.
package kdlp_pkg;

  // Event codes reported per key
  typedef enum logic [2:0] {
    EV_RELEASED = 3'd0,
    EV_DOWN     = 3'd1,
    EV_UP       = 3'd2,
    EV_PRESSED  = 3'd3,
    EV_LONG     = 3'd4
  } key_event_e;

  // Configuration register indexes
  localparam logic CFG_DEBOUNCE   = 1'b0;
  localparam logic CFG_LONG_PRESS = 1'b1;

  // Reset values of the configuration registers
  localparam logic [15:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;

  // Lowest bit of the button byte that belongs to key 0
  localparam int unsigned KEY_BIT_BASE = 4;

  // Status one key presents to the read path
  typedef struct packed {
    logic       pending;
    key_event_e last_event;
  } key_status_t;

endpackage

/* rtl/kdlp_key.sv */
// Per-key debounce and long-press state machine with latched event and flag.
// Depends on kdlp_pkg for event codes and the status struct.
module kdlp_key (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  sample_i,
  input  logic                  up_i,
  input  logic [31:0]           now_ms_i,
  input  logic [15:0]           debounce_ms_i,
  input  logic [15:0]           long_press_ms_i,
  input  logic                  clear_i,
  output kdlp_pkg::key_status_t status_o
);

  typedef enum logic [2:0] {
    PH_RELEASED    = 3'd0,
    PH_PRESS_DB    = 3'd1,
    PH_PRESSED     = 3'd2,
    PH_LONG        = 3'd3,
    PH_REL_DB      = 3'd4,
    PH_REL_DB_LONG = 3'd5
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [31:0]          start_q, start_d;
  kdlp_pkg::key_event_e last_q, last_d;
  logic                 pending_q, pending_d;

  logic [31:0]          held;
  logic                 db_over, long_over;
  logic                 post;
  kdlp_pkg::key_event_e post_ev;

  // Wrapped time since the phase began, against both limits
  assign held      = now_ms_i - start_q;
  assign db_over   = held > {16'd0, debounce_ms_i};
  assign long_over = held > {16'd0, long_press_ms_i};

  // Phase transitions on a sample
  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    post    = 1'b0;
    post_ev = kdlp_pkg::EV_RELEASED;
    if (sample_i) begin
      case (phase_q)
        PH_RELEASED: begin
          if (!up_i) begin
            start_d = now_ms_i;
            phase_d = PH_PRESS_DB;
            post    = 1'b1;
            post_ev = kdlp_pkg::EV_DOWN;
          end
        end
        PH_PRESS_DB: begin
          // pressed keeps the debounce start, so long press counts from there
          if (up_i) begin
            phase_d = PH_RELEASED;
            post    = 1'b1;
            post_ev = kdlp_pkg::EV_UP;
          end else if (db_over) begin
            phase_d = PH_PRESSED;
            post    = 1'b1;
            post_ev = kdlp_pkg::EV_PRESSED;
          end
        end
        PH_PRESSED: begin
          if (up_i) begin
            start_d = now_ms_i;
            phase_d = PH_REL_DB;
            post    = 1'b1;
            post_ev = kdlp_pkg::EV_UP;
          end else if (long_over) begin
            phase_d = PH_LONG;
            post    = 1'b1;
            post_ev = kdlp_pkg::EV_LONG;
          end
        end
        PH_LONG: begin
          if (up_i) begin
            start_d = now_ms_i;
            phase_d = PH_REL_DB_LONG;
            post    = 1'b1;
            post_ev = kdlp_pkg::EV_UP;
          end
        end
        PH_REL_DB, PH_REL_DB_LONG: begin
          // a bounce returns to the held phase, keeping the release time
          if (!up_i) begin
            phase_d = (phase_q == PH_REL_DB) ? PH_PRESSED : PH_LONG;
            post    = 1'b1;
            post_ev = kdlp_pkg::EV_DOWN;
          end else if (db_over) begin
            phase_d = PH_RELEASED;
            post    = 1'b1;
            post_ev = kdlp_pkg::EV_RELEASED;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // Latch an event only when it differs from the last one; a read clears the flag
  always_comb begin
    last_d    = last_q;
    pending_d = pending_q;
    if (post && (post_ev != last_q)) begin
      last_d    = post_ev;
      pending_d = 1'b1;
    end
    if (clear_i) begin
      pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_RELEASED;
      start_q   <= 32'd0;
      last_q    <= kdlp_pkg::EV_RELEASED;
      pending_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      start_q   <= start_d;
      last_q    <= last_d;
      pending_q <= pending_d;
    end
  end

  assign status_o.pending    = pending_q;
  assign status_o.last_event = last_q;

endmodule

/* rtl/key_debounce_long_press.sv */
// Top level: debounce and long-press qualifier for up to four keys.
// Depends on kdlp_pkg and kdlp_key.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------------------
//   input   | in_valid_i / in_stall_o    | action_i, buttons_i, now_ms_i, key_index_i
//   output  | out_valid_o / out_stall_i  | event_valid_o, key_event_o
//   config  | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// One transaction per cycle unless input stalls: a sample updates every key's state
// at the edge it is accepted; a read loads its result at that edge into the output
// register if free or firing (offered from the next cycle on), else the skid register.
// A two-entry output (result register plus skid register) keeps input open while
// one result waits; input stalls only while the skid register is occupied.
// Reset clears all key state and loads the default limits.
module key_debounce_long_press #(
  parameter int NUM_KEYS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  buttons_i,
  input  logic [31:0] now_ms_i,
  input  logic [2:0]  key_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        event_valid_o,
  output logic [2:0]  key_event_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] debounce_q, long_press_q;

  logic in_acc, sample, rd_acc, out_fire;
  logic [NUM_KEYS-1:0] clear;
  kdlp_pkg::key_status_t status [NUM_KEYS];

  logic       rd_valid;
  logic [2:0] rd_event;

  logic       out_valid_q, skid_valid_q;
  logic       out_ev_valid_q, skid_ev_valid_q;
  logic [2:0] out_event_q, skid_event_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= kdlp_pkg::DEBOUNCE_RST;
      long_press_q <= kdlp_pkg::LONG_PRESS_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == kdlp_pkg::CFG_DEBOUNCE) begin
        debounce_q <= cfg_data_i;
      end else begin
        long_press_q <= cfg_data_i;
      end
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign sample     = in_acc && !action_i;
  assign rd_acc     = in_acc && action_i;
  assign out_fire   = out_valid_q && !out_stall_i;

  // Key state machines
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    assign clear[k] = rd_acc && (key_index_i == 3'(k));
    kdlp_key u_key (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .sample_i        (sample),
      .up_i            (buttons_i[kdlp_pkg::KEY_BIT_BASE + k]),
      .now_ms_i        (now_ms_i),
      .debounce_ms_i   (debounce_q),
      .long_press_ms_i (long_press_q),
      .clear_i         (clear[k]),
      .status_o        (status[k])
    );
  end

  // Read select: an index past the last key matches nothing and reports no event
  always_comb begin
    rd_valid = 1'b0;
    rd_event = 3'd0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if ((key_index_i == 3'(k)) && status[k].pending) begin
        rd_valid = 1'b1;
        rd_event = status[k].last_event;
      end
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (rd_acc) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload of the two result slots
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_ev_valid_q <= skid_ev_valid_q;
        out_event_q    <= skid_event_q;
      end
    end else if (rd_acc) begin
      if (!out_valid_q || out_fire) begin
        out_ev_valid_q <= rd_valid;
        out_event_q    <= rd_event;
      end else begin
        skid_ev_valid_q <= rd_valid;
        skid_event_q    <= rd_event;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_valid_o = out_ev_valid_q;
  assign key_event_o   = out_event_q;

endmodule
